@@ rtl/core/sgrc_pkg.sv @@
// Package for the SGR attribute and colour tracker.
// Holds beat types, SGR code constants, colour select codes and the palette builder.
// No dependencies.
package sgrc_pkg;

    typedef struct packed {
        logic        kind;
        logic [15:0] param_value;
        logic        last_in_sequence;
    } t_in_beat;

    typedef struct packed {
        logic [8:0]  attribute_bits;
        logic [31:0] foreground_argb;
        logic [31:0] background_argb;
    } t_out_beat;

    typedef logic [255:0][23:0] t_pal_tab;

    // Register indexes
    localparam logic REG_DEFAULT_FG = 1'b0;
    localparam logic REG_DEFAULT_BG = 1'b1;

    localparam logic [31:0] DEFAULT_FG_RESET = 32'hffe1e1e1;
    localparam logic [31:0] DEFAULT_BG_RESET = 32'hff000000;
    localparam logic [7:0]  ALPHA_OPAQUE     = 8'hff;

    // Extended colour phases
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_SEL   = 3'd1;
    localparam logic [2:0] PH_RED   = 3'd2;
    localparam logic [2:0] PH_GREEN = 3'd3;
    localparam logic [2:0] PH_BLUE  = 3'd4;
    localparam logic [2:0] PH_INDEX = 3'd5;

    // Colour update selects
    localparam logic [1:0] SEL_KEEP = 2'd0;
    localparam logic [1:0] SEL_DFLT = 2'd1;
    localparam logic [1:0] SEL_PAL  = 2'd2;
    localparam logic [1:0] SEL_RGB  = 2'd3;

    // SGR codes
    localparam logic [15:0] SGR_RESET      = 16'd0;
    localparam logic [15:0] SGR_SET_FIRST  = 16'd1;
    localparam logic [15:0] SGR_SET_GAP    = 16'd6;
    localparam logic [15:0] SGR_SET_LAST   = 16'd9;
    localparam logic [15:0] SGR_DBL_UNDER  = 16'd21;
    localparam logic [15:0] SGR_NORMAL     = 16'd22;
    localparam logic [15:0] SGR_CLR_FIRST  = 16'd23;
    localparam logic [15:0] SGR_CLR_GAP    = 16'd26;
    localparam logic [15:0] SGR_CLR_LAST   = 16'd29;
    localparam logic [15:0] SGR_FG_FIRST   = 16'd30;
    localparam logic [15:0] SGR_FG_LAST    = 16'd37;
    localparam logic [15:0] SGR_FG_EXT     = 16'd38;
    localparam logic [15:0] SGR_FG_DFLT    = 16'd39;
    localparam logic [15:0] SGR_BG_FIRST   = 16'd40;
    localparam logic [15:0] SGR_BG_LAST    = 16'd47;
    localparam logic [15:0] SGR_BG_EXT     = 16'd48;
    localparam logic [15:0] SGR_BG_DFLT    = 16'd49;
    localparam logic [15:0] SGR_FGB_FIRST  = 16'd90;
    localparam logic [15:0] SGR_FGB_LAST   = 16'd97;
    localparam logic [15:0] SGR_BGB_FIRST  = 16'd100;
    localparam logic [15:0] SGR_BGB_LAST   = 16'd107;
    localparam logic [15:0] SGR_EXT_RGB    = 16'd2;
    localparam logic [15:0] SGR_EXT_INDEX  = 16'd5;

    localparam int CUBE_STEP = 41;

    function automatic t_pal_tab sgrc_build_palette();
        t_pal_tab tab;
        logic [23:0] base [16];
        int idx;
        int p;
        base[0]  = 24'h000000; base[1]  = 24'hc00000; base[2]  = 24'h00c000;
        base[3]  = 24'hc0c000; base[4]  = 24'h0000c0; base[5]  = 24'hc000c0;
        base[6]  = 24'h00c0c0; base[7]  = 24'he1e1e1; base[8]  = 24'h808080;
        base[9]  = 24'hff0000; base[10] = 24'h00ff00; base[11] = 24'hffff00;
        base[12] = 24'h0000ff; base[13] = 24'hff00ff; base[14] = 24'h00ffff;
        base[15] = 24'hffffff;
        for (int i = 0; i < 16; i++) begin
            tab[i] = base[i];
        end
        for (int r = 0; r < 6; r++) begin
            for (int g = 0; g < 6; g++) begin
                for (int b = 0; b < 6; b++) begin
                    idx = 16 + 36 * r + 6 * g + b;
                    tab[idx] = {8'(r * CUBE_STEP), 8'(g * CUBE_STEP), 8'(b * CUBE_STEP)};
                end
            end
        end
        for (int k = 0; k < 24; k++) begin
            p = (85 * k) >> 3;
            tab[232 + k] = {8'(p), 8'(p), 8'(p)};
        end
        return tab;
    endfunction

endpackage

@@ rtl/core/sgr_attribute_color_tracker.sv @@
// SGR attribute and colour tracker, top level.
// Depends on sgrc_pkg for beat types, SGR codes and the palette contents.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------
//  in      | in        | i_in_valid / o_in_ready   | i_in_data  (t_in_beat)
//  out     | out       | o_out_valid / i_out_ready | o_out_data (t_out_beat)
//  cfg     | in        | i_cfg_we, no wait         | i_cfg_index, i_cfg_data
//
// One beat a cycle sustained while the output is not stalled. A beat is registered
// into stage one, then into the output register. Stage one decodes the parameter,
// updates attributes and extended-colour state and reads the palette ROM (one
// synchronous read port); stage two resolves the colours and loads the output register.
// Synchronous active-low reset; the palette needs no clearing pass.
// A stalled output holds the pipeline; input ready drops only when both stages are full.
module sgr_attribute_color_tracker
    import sgrc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_beat    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_beat   o_out_data,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    typedef struct packed {
        logic [8:0]  attr;
        logic [1:0]  fg_sel;
        logic [1:0]  bg_sel;
        logic [23:0] rgb;
    } t_s1;

    localparam t_pal_tab PALETTE = sgrc_build_palette();

    logic [31:0] r_dflt_fg, r_dflt_bg;
    logic [8:0]  r_attr, n_attr;
    logic [2:0]  r_phase, n_phase;
    logic        r_tgt_bg, n_tgt_bg;
    logic [15:0] r_partial, n_partial;
    logic [31:0] r_fg, n_fg, r_bg, n_bg;
    logic        r_s1_valid;
    t_s1         r_s1, n_s1;
    logic [23:0] r_pal_q;
    logic [7:0]  pal_idx;
    logic        r_out_valid;
    t_out_beat   r_out;

    logic        accept, s1_go, run_ord;
    logic [15:0] v;
    logic [7:0]  lo;
    logic [7:0]  ofs_fg, ofs_bg, ofs_fgb, ofs_bgb;
    logic [3:0]  set_bit, clr_bit;

    assign s1_go      = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_go;
    assign accept     = i_in_valid && o_in_ready;

    assign v       = i_in_data.param_value;
    assign lo      = v[7:0];
    assign ofs_fg  = lo - 8'(SGR_FG_FIRST);
    assign ofs_bg  = lo - 8'(SGR_BG_FIRST);
    assign ofs_fgb = lo - 8'(SGR_FGB_FIRST) + 8'd8;
    assign ofs_bgb = lo - 8'(SGR_BGB_FIRST) + 8'd8;
    assign set_bit = (v < SGR_SET_GAP) ? 4'(lo - 8'd1) : 4'(lo - 8'd2);
    assign clr_bit = (v < SGR_CLR_GAP) ? 4'(lo - 8'd21) : 4'(lo - 8'd22);

    // Decode one parameter against the current extended-colour phase
    always_comb begin
        n_attr    = r_attr;
        n_phase   = r_phase;
        n_tgt_bg  = r_tgt_bg;
        n_partial = r_partial;
        n_s1      = '{attr: '0, fg_sel: SEL_KEEP, bg_sel: SEL_KEEP, rgb: '0};
        pal_idx   = '0;
        run_ord   = 1'b0;

        if (i_in_data.kind) begin
            n_attr      = '0;
            n_s1.fg_sel = SEL_DFLT;
            n_s1.bg_sel = SEL_DFLT;
            n_phase     = PH_IDLE;
            n_partial   = '0;
        end else begin
            unique case (r_phase)
                PH_IDLE: run_ord = 1'b1;
                PH_SEL: begin
                    if (v == SGR_EXT_RGB) begin
                        n_phase = PH_RED;
                    end else if (v == SGR_EXT_INDEX) begin
                        n_phase = PH_INDEX;
                    end else begin
                        n_phase = PH_IDLE;
                        run_ord = 1'b1;
                    end
                end
                PH_RED: begin
                    n_partial = {lo, 8'h00};
                    n_phase   = PH_GREEN;
                end
                PH_GREEN: begin
                    n_partial = {r_partial[15:8], lo};
                    n_phase   = PH_BLUE;
                end
                PH_BLUE: begin
                    n_s1.rgb = {r_partial, lo};
                    if (r_tgt_bg) n_s1.bg_sel = SEL_RGB;
                    else          n_s1.fg_sel = SEL_RGB;
                    n_phase = PH_IDLE;
                end
                PH_INDEX: begin
                    pal_idx = lo;
                    if (r_tgt_bg) n_s1.bg_sel = SEL_PAL;
                    else          n_s1.fg_sel = SEL_PAL;
                    n_phase = PH_IDLE;
                end
                default: n_phase = PH_IDLE;
            endcase

            if (run_ord) begin
                priority if (v == SGR_RESET) begin
                    n_attr      = '0;
                    n_s1.fg_sel = SEL_DFLT;
                    n_s1.bg_sel = SEL_DFLT;
                end else if (v >= SGR_SET_FIRST && v <= SGR_SET_LAST && v != SGR_SET_GAP) begin
                    n_attr = r_attr | (9'd1 << set_bit);
                end else if (v == SGR_DBL_UNDER) begin
                    n_attr = r_attr | 9'h100;
                end else if (v == SGR_NORMAL) begin
                    n_attr = r_attr & ~9'h003;
                end else if (v >= SGR_CLR_FIRST && v <= SGR_CLR_LAST && v != SGR_CLR_GAP) begin
                    n_attr = r_attr & ~(9'd1 << clr_bit);
                end else if (v >= SGR_FG_FIRST && v <= SGR_FG_LAST) begin
                    pal_idx     = ofs_fg;
                    n_s1.fg_sel = SEL_PAL;
                end else if (v == SGR_FG_EXT || v == SGR_BG_EXT) begin
                    n_phase  = PH_SEL;
                    n_tgt_bg = (v == SGR_BG_EXT);
                end else if (v == SGR_FG_DFLT) begin
                    n_s1.fg_sel = SEL_DFLT;
                end else if (v >= SGR_BG_FIRST && v <= SGR_BG_LAST) begin
                    pal_idx     = ofs_bg;
                    n_s1.bg_sel = SEL_PAL;
                end else if (v == SGR_BG_DFLT) begin
                    n_s1.bg_sel = SEL_DFLT;
                end else if (v >= SGR_FGB_FIRST && v <= SGR_FGB_LAST) begin
                    pal_idx     = ofs_fgb;
                    n_s1.fg_sel = SEL_PAL;
                end else if (v >= SGR_BGB_FIRST && v <= SGR_BGB_LAST) begin
                    pal_idx     = ofs_bgb;
                    n_s1.bg_sel = SEL_PAL;
                end else begin
                    n_attr = r_attr;
                end
            end

            // End of sequence: complete a pending extended colour with zeros
            if (i_in_data.last_in_sequence) begin
                unique case (n_phase)
                    PH_RED, PH_GREEN, PH_BLUE: begin
                        n_s1.rgb = (n_phase == PH_RED)   ? 24'h000000 :
                                   (n_phase == PH_GREEN) ? {n_partial[15:8], 16'h0000} :
                                                           {n_partial, 8'h00};
                        if (n_tgt_bg) n_s1.bg_sel = SEL_RGB;
                        else          n_s1.fg_sel = SEL_RGB;
                    end
                    PH_INDEX: begin
                        pal_idx = '0;
                        if (n_tgt_bg) n_s1.bg_sel = SEL_PAL;
                        else          n_s1.fg_sel = SEL_PAL;
                    end
                    default: ;
                endcase
                n_phase = PH_IDLE;
            end
        end
        n_s1.attr = n_attr;
    end

    // Resolve colours for the beat in stage one
    always_comb begin
        unique case (r_s1.fg_sel)
            SEL_KEEP: n_fg = r_fg;
            SEL_DFLT: n_fg = r_dflt_fg;
            SEL_PAL:  n_fg = {ALPHA_OPAQUE, r_pal_q};
            SEL_RGB:  n_fg = {ALPHA_OPAQUE, r_s1.rgb};
            default:  n_fg = r_fg;
        endcase
        unique case (r_s1.bg_sel)
            SEL_KEEP: n_bg = r_bg;
            SEL_DFLT: n_bg = r_dflt_bg;
            SEL_PAL:  n_bg = {ALPHA_OPAQUE, r_pal_q};
            SEL_RGB:  n_bg = {ALPHA_OPAQUE, r_s1.rgb};
            default:  n_bg = r_bg;
        endcase
    end

    // Palette ROM, registered read; hold the data while stage one stalls
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pal_q <= PALETTE[pal_idx];
            r_s1    <= n_s1;
        end
        if (s1_go) begin
            r_out <= '{attribute_bits: r_s1.attr, foreground_argb: n_fg, background_argb: n_bg};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dflt_fg   <= DEFAULT_FG_RESET;
            r_dflt_bg   <= DEFAULT_BG_RESET;
            r_attr      <= '0;
            r_phase     <= PH_IDLE;
            r_tgt_bg    <= 1'b0;
            r_partial   <= '0;
            r_fg        <= DEFAULT_FG_RESET;
            r_bg        <= DEFAULT_BG_RESET;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_DEFAULT_FG: r_dflt_fg <= i_cfg_data;
                    REG_DEFAULT_BG: r_dflt_bg <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                r_attr    <= n_attr;
                r_phase   <= n_phase;
                r_tgt_bg  <= n_tgt_bg;
                r_partial <= n_partial;
            end
            if (s1_go) begin
                r_fg <= n_fg;
                r_bg <= n_bg;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
